@@ rtl/bdps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdps_pkg
// Shared types and codes for the button debounce and diameter setting unit.
// ----------------------------------------------------------------------------
package bdps_pkg;

  // event kinds carried on the input tuser
  localparam logic [1:0] OP_PRESS_ONE = 2'd0;
  localparam logic [1:0] OP_PRESS_TWO = 2'd1;
  localparam logic [1:0] OP_LOAD      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_DOUBLE     = 2'd1;
  localparam logic [1:0] CFG_MIN_DIAM   = 2'd2;
  localparam logic [1:0] CFG_MAX_DIAM   = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] DOUBLE_RST   = 16'd500;
  localparam logic [7:0]  MIN_DIAM_RST = 8'd30;
  localparam logic [7:0]  MAX_DIAM_RST = 8'd100;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [7:0]  max_diameter_cm;
    logic [7:0]  min_diameter_cm;
    logic [15:0] double_press_window_ms;
    logic [15:0] debounce_window_ms;
  } cfg_t;

  // packed so that the last field lands in the lowest bit
  typedef struct packed {
    logic [7:0] shown_value;
    logic [7:0] diameter_now;
    logic       save_request;
    logic       diameter_stepped;
    logic       mode_toggled;
    logic       settings_active;
    logic       accepted;
  } res_t;

endpackage

@@ rtl/button_debounce_double_press_setting_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_double_press_setting_unit
// Debounced two-button control of a wheel diameter with a double-press
// settings mode, one result beat per event beat.
// ----------------------------------------------------------------------------
//  channel | direction | tuser          | tdata (lowest bit up)
//  in_     | slave     | opcode[1:0]    | time_ms[31:0], load_value[7:0]
//  out_    | master    | -              | accepted, settings_active,
//          |           |                | mode_toggled, diameter_stepped,
//          |           |                | save_request, diameter_now[7:0],
//          |           |                | shown_value[7:0], 3 zero bits
//  cfg_    | write     | -              | cfg_addr picks the register
//
//  one event per cycle while the result is not stalled; input register, then
//  result register, with the state update done in one pass between them
//  reset clears the valid flags, the button state and the registers to
//  their defaults
//  a stalled result holds; the input stage keeps taking beats while the
//  result register is free or being drained
// ----------------------------------------------------------------------------
module button_debounce_double_press_setting_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bdps_pkg::IN_DATA_W-1:0]  in_tdata,   // time_ms, load_value
  input  logic [1:0]                      in_tuser,   // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bdps_pkg::OUT_DATA_W-1:0] out_tdata,  // accepted .. shown_value
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [15:0]                     cfg_wdata
);
  import bdps_pkg::*;

  cfg_t                 cfg_r;
  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  logic [31:0]          s1_time_r;
  logic [7:0]           s1_load_r;
  logic                 out_valid_r;
  res_t                 out_res_r;

  logic [TIME_BITS-1:0] last_one_r;
  logic [TIME_BITS-1:0] last_two_r;
  logic [TIME_BITS-1:0] prior_r;
  logic                 mode_r;
  logic [7:0]           diam_r;
  logic [7:0]           disp_r;

  logic [TIME_BITS-1:0] last_one_nxt;
  logic [TIME_BITS-1:0] last_two_nxt;
  logic [TIME_BITS-1:0] prior_nxt;
  logic                 mode_nxt;
  logic [7:0]           diam_nxt;
  logic [7:0]           disp_nxt;
  res_t                 res;

  logic [TIME_BITS-1:0] now;
  logic                 s1_adv;

  generate
    if (TIME_BITS >= 32) begin : g_time_wide
      assign now = TIME_BITS'(s1_time_r);
    end else begin : g_time_narrow
      assign now = s1_time_r[TIME_BITS-1:0];
    end
  endgenerate

  assign s1_adv     = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_res_r};

  bdps_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .op              (s1_op_r),
    .now             (now),
    .load_value      (s1_load_r),
    .cfg             (cfg_r),
    .last_one        (last_one_r),
    .last_two        (last_two_r),
    .prior_press     (prior_r),
    .mode            (mode_r),
    .diam            (diam_r),
    .disp            (disp_r),
    .last_one_nxt    (last_one_nxt),
    .last_two_nxt    (last_two_nxt),
    .prior_press_nxt (prior_nxt),
    .mode_nxt        (mode_nxt),
    .diam_nxt        (diam_nxt),
    .disp_nxt        (disp_nxt),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_window_ms     <= DEBOUNCE_RST;
      cfg_r.double_press_window_ms <= DOUBLE_RST;
      cfg_r.min_diameter_cm        <= MIN_DIAM_RST;
      cfg_r.max_diameter_cm        <= MAX_DIAM_RST;
      s1_valid_r                   <= 1'b0;
      out_valid_r                  <= 1'b0;
      last_one_r                   <= '0;
      last_two_r                   <= '0;
      prior_r                      <= '0;
      mode_r                       <= 1'b0;
      diam_r                       <= '0;
      disp_r                       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DEBOUNCE: cfg_r.debounce_window_ms     <= cfg_wdata;
          CFG_DOUBLE:   cfg_r.double_press_window_ms <= cfg_wdata;
          CFG_MIN_DIAM: cfg_r.min_diameter_cm        <= cfg_wdata[7:0];
          CFG_MAX_DIAM: cfg_r.max_diameter_cm        <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
        // state moves only when the event leaves the input stage
        if (s1_valid_r) begin
          last_one_r <= last_one_nxt;
          last_two_r <= last_two_nxt;
          prior_r    <= prior_nxt;
          mode_r     <= mode_nxt;
          diam_r     <= diam_nxt;
          disp_r     <= disp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_time_r <= in_tdata[31:0];
      s1_load_r <= in_tdata[39:32];
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= res;
    end
  end

endmodule

@@ rtl/bdps_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdps_eval
// Single-event update: debounce, double-press toggle, diameter stepping and load.
// ----------------------------------------------------------------------------
module bdps_eval #(
  parameter int TIME_BITS = 32
) (
  input  logic [1:0]           op,
  input  logic [TIME_BITS-1:0] now,
  input  logic [7:0]           load_value,
  input  bdps_pkg::cfg_t       cfg,
  input  logic [TIME_BITS-1:0] last_one,
  input  logic [TIME_BITS-1:0] last_two,
  input  logic [TIME_BITS-1:0] prior_press,
  input  logic                 mode,
  input  logic [7:0]           diam,
  input  logic [7:0]           disp,
  output logic [TIME_BITS-1:0] last_one_nxt,
  output logic [TIME_BITS-1:0] last_two_nxt,
  output logic [TIME_BITS-1:0] prior_press_nxt,
  output logic                 mode_nxt,
  output logic [7:0]           diam_nxt,
  output logic [7:0]           disp_nxt,
  output bdps_pkg::res_t       res
);
  import bdps_pkg::*;

  logic [TIME_BITS-1:0] el_btn;
  logic [TIME_BITS-1:0] el_prior;
  logic                 deb_ok;
  logic                 dbl_hit;
  logic [8:0]           up9;
  logic [7:0]           diam_inc;
  logic [7:0]           diam_m1;
  logic [7:0]           diam_dec;
  logic                 acc;
  logic                 tog;
  logic                 step;
  logic                 save;

  // wrapping differences, unsigned modulo 2^TIME_BITS
  assign el_btn   = now - (op[0] ? last_two : last_one);
  assign el_prior = now - prior_press;
  assign deb_ok   = el_btn >= TIME_BITS'(cfg.debounce_window_ms);
  assign dbl_hit  = el_prior < TIME_BITS'(cfg.double_press_window_ms);

  assign up9      = {1'b0, diam} + 9'd1;
  assign diam_inc = (up9 < {1'b0, cfg.max_diameter_cm}) ? up9[7:0] : cfg.max_diameter_cm;
  assign diam_m1  = diam - 8'd1;
  // zero steps down to the floor, never wraps
  assign diam_dec = ((diam != 8'd0) && (diam_m1 > cfg.min_diameter_cm)) ?
                    diam_m1 : cfg.min_diameter_cm;

  always_comb begin
    last_one_nxt    = last_one;
    last_two_nxt    = last_two;
    prior_press_nxt = prior_press;
    mode_nxt        = mode;
    diam_nxt        = diam;
    disp_nxt        = disp;
    acc             = 1'b0;
    tog             = 1'b0;
    step            = 1'b0;
    save            = 1'b0;
    case (op)
      OP_LOAD: begin
        diam_nxt = load_value;
        acc      = 1'b1;
      end
      OP_PRESS_ONE: begin
        if (deb_ok) begin
          acc             = 1'b1;
          last_one_nxt    = now;
          prior_press_nxt = now;
          if (dbl_hit) begin
            mode_nxt = !mode;
            tog      = 1'b1;
            disp_nxt = diam;
            save     = mode;
          end else if (mode) begin
            diam_nxt = diam_inc;
            disp_nxt = diam_inc;
            step     = 1'b1;
          end
        end
      end
      OP_PRESS_TWO: begin
        if (deb_ok) begin
          acc          = 1'b1;
          last_two_nxt = now;
          if (mode) begin
            diam_nxt = diam_dec;
            disp_nxt = diam_dec;
            step     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res.accepted         = acc;
  assign res.settings_active  = mode_nxt;
  assign res.mode_toggled     = tog;
  assign res.diameter_stepped = step;
  assign res.save_request     = save;
  assign res.diameter_now     = diam_nxt;
  assign res.shown_value      = disp_nxt;

endmodule

@@ rtl/bdps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdps_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bdps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result beat keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a save only comes from a toggle that left settings mode
  a_save_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[2] && !out_tdata[1] && out_tdata[0])
    else $error("save request without leaving settings mode");

  // stepping needs an accepted press in settings mode and no toggle
  a_step_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[0] && out_tdata[1] && !out_tdata[2]
      && (out_tdata[12:5] == out_tdata[20:13]))
    else $error("diameter step outside settings mode");

endmodule

bind button_debounce_double_press_setting_unit bdps_checker u_bdps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
